// File: rtl/usb_control_request_responder_defines.svh
// Assertion helpers shared by the responder modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef USB_CONTROL_REQUEST_RESPONDER_DEFINES_SVH
`define USB_CONTROL_REQUEST_RESPONDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UCRR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define UCRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ucrr_pkg.sv
package ucrr_pkg;

	// Result kinds on the response channel
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_ZLP   = 2'd1,
		KIND_ACK   = 2'd2,
		KIND_STALL = 2'd3
	} kind_t;

	// Standard request codes
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;

	// Descriptor types (high byte of the value word)
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_HID    = 8'h21;
	localparam logic [7:0] DESC_REPORT = 8'h22;

	// Descriptor sizes; index width covers the longest one
	localparam int IDX_W = 6;
	localparam logic [IDX_W-1:0] LEN_DEVICE = 6'd18;
	localparam logic [IDX_W-1:0] LEN_CONFIG = 6'd34;
	localparam logic [IDX_W-1:0] LEN_HID    = 6'd9;
	localparam logic [IDX_W-1:0] LEN_REPORT = 6'd45;
	localparam logic [IDX_W-1:0] OFS_HID    = 6'd18;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_CODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd3;

	// Register reset values
	localparam logic [15:0] RST_VENDOR_CODE   = 16'h046A;
	localparam logic [15:0] RST_PRODUCT_CODE  = 16'h0001;
	localparam logic [7:0]  RST_MAX_POWER     = 8'd50;
	localparam logic [7:0]  RST_POLL_INTERVAL = 8'd1;

	// Decoded response class of the held request
	typedef enum logic [2:0] {
		RESP_STREAM,
		RESP_ZLP,
		RESP_ACK,
		RESP_SETADDR,
		RESP_STALL
	} resp_t;

	// Descriptor source select
	typedef enum logic [1:0] {
		SEL_DEVICE,
		SEL_CONFIG,
		SEL_HID,
		SEL_REPORT
	} sel_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REPLY,
		ST_STREAM
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic start;
		logic set_addr;
		logic load_single;
		logic load_byte;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		resp_t resp;
		logic  last_byte;
		logic  slot_free;
	} status_t;

endpackage

// File: rtl/ucrr_ifs.sv
// Setup request channel
interface ucrr_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_index;
	logic [15:0] request_length;

	modport source (
		output valid, request_type, request_code, request_value, request_index,
		       request_length,
		input  ready
	);
	modport sink (
		input  valid, request_type, request_code, request_value, request_index,
		       request_length,
		output ready
	);
endinterface

// Result channel
interface ucrr_rsp_if;
	logic            valid;
	logic            ready;
	ucrr_pkg::kind_t kind;
	logic [7:0]      data_byte;
	logic            packet_end;
	logic            last;
	logic [6:0]      device_address;
	logic            address_enabled;

	modport source (
		output valid, kind, data_byte, packet_end, last, device_address,
		       address_enabled,
		input  ready
	);
	modport sink (
		input  valid, kind, data_byte, packet_end, last, device_address,
		       address_enabled,
		output ready
	);
endinterface

// File: rtl/usb_control_request_responder.sv
// Standard control request responder for a boot keyboard's EP0.
// req carries one decoded setup packet per transaction (valid/ready);
// rsp returns the results of that request, one per transaction.
// GET_DESCRIPTOR streams min(request_length, descriptor size) bytes, one
// per cycle, with packet_end on every EP0_PACKET_BYTES-th byte and on the
// final one; a zero request_length gives one zero-length result. Other
// supported requests give one acknowledge, unsupported ones one stall.
// last marks the final result of every request.
// Timing: a request is taken in the idle cycle, decoded in the next, and
// its first result is loaded into the output register in the reply or
// stream state once that register is free. The block takes the next
// request only after the final result of the current one is loaded; the
// descriptor stream loads one byte per cycle while the register is free.
// The output register holds one finished result, so a new request is taken
// while that result waits; a stall on rsp holds the stream in place.
// Reset clears the device address, restores the configuration registers to
// their defaults and leaves the block idle with rsp empty.
module usb_control_request_responder #(
	parameter int EP0_PACKET_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ucrr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ucrr_pkg::CFG_DATA_W-1:0]   cfg_data,
	ucrr_req_if.sink                          req,
	ucrr_rsp_if.source                        rsp
);

	ucrr_pkg::cmd_t    cmd;
	ucrr_pkg::status_t sts;

	// Sequence the request
	ucrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Decode, descriptor bytes and result register
	ucrr_datapath #(
		.EP0_PACKET_BYTES (EP0_PACKET_BYTES)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.request_type        (req.request_type),
		.request_code        (req.request_code),
		.request_value       (req.request_value),
		.request_index       (req.request_index),
		.request_length      (req.request_length),
		.rsp_ready           (rsp.ready),
		.rsp_valid           (rsp.valid),
		.rsp_kind            (rsp.kind),
		.rsp_data_byte       (rsp.data_byte),
		.rsp_packet_end      (rsp.packet_end),
		.rsp_last            (rsp.last),
		.rsp_device_address  (rsp.device_address),
		.rsp_address_enabled (rsp.address_enabled),
		.cmd                 (cmd),
		.sts                 (sts)
	);

endmodule

// File: rtl/ucrr_ctrl.sv
`include "usb_control_request_responder_defines.svh"

module ucrr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ucrr_pkg::status_t  sts,
	output ucrr_pkg::cmd_t     cmd
);

	ucrr_pkg::state_t state_q;
	ucrr_pkg::state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucrr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ucrr_pkg::ST_IDLE: begin
				if (req_valid) state_next = ucrr_pkg::ST_DECODE;
			end
			ucrr_pkg::ST_DECODE: begin
				if (sts.resp == ucrr_pkg::RESP_STREAM) state_next = ucrr_pkg::ST_STREAM;
				else state_next = ucrr_pkg::ST_REPLY;
			end
			ucrr_pkg::ST_REPLY: begin
				if (sts.slot_free) state_next = ucrr_pkg::ST_IDLE;
			end
			ucrr_pkg::ST_STREAM: begin
				if (sts.slot_free && sts.last_byte) state_next = ucrr_pkg::ST_IDLE;
			end
			default: state_next = ucrr_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ucrr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			ucrr_pkg::ST_DECODE: begin
				cmd.start = (sts.resp == ucrr_pkg::RESP_STREAM);
				cmd.set_addr = (sts.resp == ucrr_pkg::RESP_SETADDR);
			end
			ucrr_pkg::ST_REPLY: begin
				cmd.load_single = sts.slot_free;
			end
			ucrr_pkg::ST_STREAM: begin
				cmd.load_byte = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Never load into an occupied output register
	`UCRR_ASSERT_NOW(a_load_slot, (cmd.load_single || cmd.load_byte), sts.slot_free,
		"result loaded while output register busy")
	// Final byte of a transfer returns the controller to idle
	`UCRR_ASSERT_NEXT(a_stream_end, (cmd.load_byte && sts.last_byte),
		(state_q == ucrr_pkg::ST_IDLE), "stream did not end after last byte")
	// A captured request is decoded in the following cycle
	`UCRR_ASSERT_NEXT(a_capture_decode, cmd.capture, (state_q == ucrr_pkg::ST_DECODE),
		"captured request not decoded")

endmodule

// File: rtl/ucrr_datapath.sv
`include "usb_control_request_responder_defines.svh"

module ucrr_datapath #(
	parameter int EP0_PACKET_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [ucrr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ucrr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request payload
	input  logic [7:0]                        request_type,
	input  logic [7:0]                        request_code,
	input  logic [15:0]                       request_value,
	input  logic [15:0]                       request_index,
	input  logic [15:0]                       request_length,
	// result register
	input  logic                              rsp_ready,
	output logic                              rsp_valid,
	output ucrr_pkg::kind_t                   rsp_kind,
	output logic [7:0]                        rsp_data_byte,
	output logic                              rsp_packet_end,
	output logic                              rsp_last,
	output logic [6:0]                        rsp_device_address,
	output logic                              rsp_address_enabled,
	// controller link
	input  ucrr_pkg::cmd_t                    cmd,
	output ucrr_pkg::status_t                 sts
);

	localparam int IW = ucrr_pkg::IDX_W;
	localparam int PW = (EP0_PACKET_BYTES > 1) ? $clog2(EP0_PACKET_BYTES) : 1;
	localparam logic [PW-1:0] PKT_LAST = PW'(EP0_PACKET_BYTES - 1);

	// Byte offsets that carry configurable fields
	localparam logic [IW-1:0] OFS_MAXPKT   = 6'd7;
	localparam logic [IW-1:0] OFS_VID_LO   = 6'd8;
	localparam logic [IW-1:0] OFS_VID_HI   = 6'd9;
	localparam logic [IW-1:0] OFS_PID_LO   = 6'd10;
	localparam logic [IW-1:0] OFS_PID_HI   = 6'd11;
	localparam logic [IW-1:0] OFS_POWER    = 6'd8;
	localparam logic [IW-1:0] OFS_INTERVAL = 6'd33;

	localparam logic [7:0] DEV_ROM [18] = '{
		8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
	};
	localparam logic [7:0] CFG_ROM [34] = '{
		8'd9, 8'h02, 8'd34, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h00,
		8'd9, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
		8'd9, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'd45, 8'h00,
		8'd7, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h00
	};
	localparam logic [7:0] REP_ROM [45] = '{
		8'h05, 8'h01, 8'h09, 8'h06, 8'ha1, 8'h01,
		8'h95, 8'h08, 8'h75, 8'h01, 8'h05, 8'h07, 8'h19, 8'he0, 8'h29, 8'he7,
		8'h15, 8'h00, 8'h25, 8'h01, 8'h81, 8'h02,
		8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01,
		8'h95, 8'h06, 8'h75, 8'h08, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
		8'h15, 8'h00, 8'h25, 8'h65, 8'h81, 8'h00,
		8'hc0
	};

	// configuration registers
	logic [15:0] vendor_code_q;
	logic [15:0] product_code_q;
	logic [7:0]  max_power_q;
	logic [7:0]  poll_interval_q;

	// held request
	logic [7:0]  rtype_q;
	logic [7:0]  code_q;
	logic [15:0] value_q;
	logic [15:0] index_q;
	logic [15:0] length_q;

	// stream counters
	logic [IW-1:0] idx_q;
	logic [IW-1:0] n_q;
	logic [PW-1:0] pkt_q;

	// device address
	logic [6:0] addr_q;
	logic       addr_on_q;

	// output register
	logic            out_valid_q;
	ucrr_pkg::kind_t out_kind_q;
	logic [7:0]      out_data_q;
	logic            out_pend_q;
	logic            out_last_q;
	logic [6:0]      out_addr_q;
	logic            out_addr_on_q;

	// decode
	ucrr_pkg::resp_t resp;
	ucrr_pkg::sel_t  sel;
	logic [IW-1:0]   size;
	logic [IW-1:0]   n_cap;
	logic            get_desc;
	logic            simple_ok;
	logic            found;
	logic            last_byte;
	logic            pkt_end;
	logic            slot_free;
	logic [7:0]      rom_byte;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_code_q   <= ucrr_pkg::RST_VENDOR_CODE;
			product_code_q  <= ucrr_pkg::RST_PRODUCT_CODE;
			max_power_q     <= ucrr_pkg::RST_MAX_POWER;
			poll_interval_q <= ucrr_pkg::RST_POLL_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_index)
				ucrr_pkg::CFG_VENDOR_CODE:   vendor_code_q <= cfg_data;
				ucrr_pkg::CFG_PRODUCT_CODE:  product_code_q <= cfg_data;
				ucrr_pkg::CFG_MAX_POWER:     max_power_q <= cfg_data[7:0];
				ucrr_pkg::CFG_POLL_INTERVAL: poll_interval_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rtype_q  <= request_type;
			code_q   <= request_code;
			value_q  <= request_value;
			index_q  <= request_index;
			length_q <= request_length;
		end
	end

	// Decode the held request
	always_comb begin
		resp = ucrr_pkg::RESP_STALL;
		sel = ucrr_pkg::SEL_DEVICE;
		size = ucrr_pkg::LEN_DEVICE;
		found = 1'b0;
		get_desc = (code_q == ucrr_pkg::REQ_GET_DESCRIPTOR) && rtype_q[7]
			&& (rtype_q[6:5] == 2'b00);
		simple_ok = (rtype_q == 8'h00) && (index_q == 16'h0000) && (length_q == 16'h0000);
		if (get_desc) begin
			if ((value_q[7:0] == 8'h00) && (index_q == 16'h0000)) begin
				found = 1'b1;
				case (value_q[15:8])
					ucrr_pkg::DESC_DEVICE: begin
						sel = ucrr_pkg::SEL_DEVICE;
						size = ucrr_pkg::LEN_DEVICE;
					end
					ucrr_pkg::DESC_CONFIG: begin
						sel = ucrr_pkg::SEL_CONFIG;
						size = ucrr_pkg::LEN_CONFIG;
					end
					ucrr_pkg::DESC_HID: begin
						sel = ucrr_pkg::SEL_HID;
						size = ucrr_pkg::LEN_HID;
					end
					ucrr_pkg::DESC_REPORT: begin
						sel = ucrr_pkg::SEL_REPORT;
						size = ucrr_pkg::LEN_REPORT;
					end
					default: found = 1'b0;
				endcase
			end
			if (found) begin
				resp = (length_q == 16'h0000) ? ucrr_pkg::RESP_ZLP : ucrr_pkg::RESP_STREAM;
			end
		end else if ((code_q == ucrr_pkg::REQ_SET_ADDRESS) && simple_ok) begin
			resp = ucrr_pkg::RESP_SETADDR;
		end else if ((code_q == ucrr_pkg::REQ_SET_CONFIG) && simple_ok) begin
			resp = ucrr_pkg::RESP_ACK;
		end
	end

	// Clip the transfer to the descriptor size
	assign n_cap = (length_q < {{(16-IW){1'b0}}, size}) ? length_q[IW-1:0] : size;

	// Descriptor byte at the stream index
	always_comb begin
		case (sel)
			ucrr_pkg::SEL_DEVICE: begin
				case (idx_q)
					OFS_MAXPKT: rom_byte = 8'(EP0_PACKET_BYTES);
					OFS_VID_LO: rom_byte = vendor_code_q[7:0];
					OFS_VID_HI: rom_byte = vendor_code_q[15:8];
					OFS_PID_LO: rom_byte = product_code_q[7:0];
					OFS_PID_HI: rom_byte = product_code_q[15:8];
					default:    rom_byte = DEV_ROM[idx_q[4:0]];
				endcase
			end
			ucrr_pkg::SEL_CONFIG: begin
				case (idx_q)
					OFS_POWER:    rom_byte = max_power_q;
					OFS_INTERVAL: rom_byte = poll_interval_q;
					default:      rom_byte = CFG_ROM[idx_q];
				endcase
			end
			ucrr_pkg::SEL_HID: rom_byte = CFG_ROM[idx_q + ucrr_pkg::OFS_HID];
			ucrr_pkg::SEL_REPORT: rom_byte = REP_ROM[idx_q];
			default: rom_byte = 8'h00;
		endcase
	end

	assign last_byte = (IW'(idx_q + 1'b1) == n_q);
	assign pkt_end = (pkt_q == PKT_LAST) || last_byte;
	assign slot_free = !out_valid_q || rsp_ready;

	// Advance stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			n_q   <= '0;
			pkt_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
			n_q   <= n_cap;
			pkt_q <= '0;
		end else if (cmd.load_byte) begin
			idx_q <= IW'(idx_q + 1'b1);
			pkt_q <= pkt_end ? '0 : PW'(pkt_q + 1'b1);
		end
	end

	// Latch and enable the device address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			addr_on_q <= 1'b0;
		end else if (cmd.set_addr) begin
			addr_q    <= value_q[6:0];
			addr_on_q <= 1'b1;
		end
	end

	// Output register valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_byte) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			out_kind_q    <= ucrr_pkg::KIND_DATA;
			out_data_q    <= rom_byte;
			out_pend_q    <= pkt_end;
			out_last_q    <= last_byte;
			out_addr_q    <= addr_q;
			out_addr_on_q <= addr_on_q;
		end else if (cmd.load_single) begin
			case (resp)
				ucrr_pkg::RESP_ZLP: begin
					out_kind_q <= ucrr_pkg::KIND_ZLP;
					out_pend_q <= 1'b1;
				end
				ucrr_pkg::RESP_ACK, ucrr_pkg::RESP_SETADDR: begin
					out_kind_q <= ucrr_pkg::KIND_ACK;
					out_pend_q <= 1'b0;
				end
				default: begin
					out_kind_q <= ucrr_pkg::KIND_STALL;
					out_pend_q <= 1'b0;
				end
			endcase
			out_data_q    <= 8'h00;
			out_last_q    <= 1'b1;
			out_addr_q    <= addr_q;
			out_addr_on_q <= addr_on_q;
		end
	end

	assign rsp_valid           = out_valid_q;
	assign rsp_kind            = out_kind_q;
	assign rsp_data_byte       = out_data_q;
	assign rsp_packet_end      = out_pend_q;
	assign rsp_last            = out_last_q;
	assign rsp_device_address  = out_addr_q;
	assign rsp_address_enabled = out_addr_on_q;

	assign sts.resp      = resp;
	assign sts.last_byte = last_byte;
	assign sts.slot_free = slot_free;

	// Stream index stays inside the clipped transfer
	`UCRR_ASSERT_NOW(a_idx_range, cmd.load_byte, (idx_q < n_q),
		"stream index past transfer length")
	// A zero-length data stage closes both the packet and the request
	`UCRR_ASSERT_NOW(a_zlp_flags, (out_valid_q && (out_kind_q == ucrr_pkg::KIND_ZLP)),
		(out_pend_q && out_last_q), "zero-length result without end flags")
	// Hold a waiting result until it is taken
	`UCRR_ASSERT_NEXT(a_rsp_hold, (out_valid_q && !rsp_ready), out_valid_q,
		"result dropped before it was taken")

endmodule

// File: test/usb_control_request_responder_tb.sv
`timescale 1ns / 100ps

module usb_control_request_responder_tb;

	localparam int EP0_BYTES = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 43;

	// Request type bytes: direction, type and recipient
	localparam logic [7:0] RT_STD_OUT = 8'h00;
	localparam logic [7:0] RT_STD_IN = 8'h80;
	localparam logic [7:0] RT_CLASS_IN = 8'hA0;
	localparam logic [7:0] RECIP_MASK = 8'h1F;

	// Requests and descriptor types the block does not support
	localparam logic [7:0] REQ_GET_STATUS = 8'h00;
	localparam logic [7:0] REQ_VENDOR_FF = 8'hFF;
	localparam logic [7:0] DESC_STRING = 8'h03;

	localparam logic [7:0] DEVICE_TMPL [18] = '{
		8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'h00, 8'h01, 8'd0, 8'd0, 8'd0, 8'd1
	};

	localparam logic [7:0] CONFIG_TMPL [34] = '{
		8'd9, 8'd2, 8'd34, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd0,
		8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'h03, 8'h01, 8'h01, 8'd0,
		8'd9, 8'h21, 8'h11, 8'h01, 8'd0, 8'd1, 8'h22, 8'd45, 8'd0,
		8'd7, 8'd5, 8'h81, 8'h03, 8'd8, 8'd0, 8'd0
	};

	localparam logic [7:0] REPORT_ROM [45] = '{
		8'h05, 8'h01, 8'h09, 8'h06, 8'ha1, 8'h01,
		8'h95, 8'h08, 8'h75, 8'h01, 8'h05, 8'h07, 8'h19, 8'he0, 8'h29, 8'he7,
		8'h15, 8'h00, 8'h25, 8'h01, 8'h81, 8'h02,
		8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01,
		8'h95, 8'h06, 8'h75, 8'h08, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
		8'h15, 8'h00, 8'h25, 8'h65, 8'h81, 8'h00,
		8'hc0
	};

	typedef struct packed {
		logic [7:0]  rtype;
		logic [7:0]  code;
		logic [15:0] value;
		logic [15:0] index;
		logic [15:0] length;
	} setup_t;

	typedef struct packed {
		ucrr_pkg::kind_t kind;
		logic [7:0]      data_byte;
		logic            packet_end;
		logic            last;
		logic [6:0]      device_address;
		logic            address_enabled;
	} reply_t;

	typedef struct {
		logic [7:0]      rtype;
		logic [7:0]      code;
		logic [15:0]     value;
		logic [15:0]     index;
		logic [15:0]     length;
		bit              typed;
		ucrr_pkg::kind_t kind;
		logic [6:0]      addr;
		bit              on;
	} probe_t;

	// Directed requests; typed rows carry the single result they must give
	probe_t probe_table [24] = '{
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h00},
			16'h0000, 16'hFFFF, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_CONFIG, 8'h00},
			16'h0000, 16'd34, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_HID, 8'h00},
			16'h0000, 16'd9, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_REPORT, 8'h00},
			16'h0000, 16'hFFFF, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h00},
			16'h0000, 16'h0000, 1'b1, ucrr_pkg::KIND_ZLP, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h00},
			16'h0000, 16'd1, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_CONFIG, 8'h00},
			16'h0000, 16'd33, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h00},
			16'h0000, 16'd255, 1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h01},
			16'h0000, 16'd18, 1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b0},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h00},
			16'hFFFF, 16'd18, 1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b0},
		'{RT_CLASS_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h00},
			16'h0000, 16'd18, 1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b0},
		'{RT_STD_OUT, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_DEVICE, 8'h00},
			16'h0000, 16'd18, 1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b0},
		'{RT_STD_IN | RECIP_MASK, ucrr_pkg::REQ_GET_DESCRIPTOR,
			{ucrr_pkg::DESC_DEVICE, 8'h00}, 16'h0000, 16'd18, 1'b0,
			ucrr_pkg::KIND_DATA, 7'h00, 1'b0},
		'{RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_ACK, 7'h00, 1'b0},
		'{RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'hFFFF,
			1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b0},
		'{RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_ACK, 7'h7F, 1'b1},
		'{RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS, 16'h0005, 16'h0001, 16'h0000,
			1'b1, ucrr_pkg::KIND_STALL, 7'h7F, 1'b1},
		'{RT_STD_OUT | 8'h01, ucrr_pkg::REQ_SET_ADDRESS, 16'h0003, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_STALL, 7'h7F, 1'b1},
		'{RT_STD_IN, ucrr_pkg::REQ_SET_ADDRESS, 16'h0003, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_STALL, 7'h7F, 1'b1},
		'{RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS, 16'h0000, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_ACK, 7'h00, 1'b1},
		'{8'hFF, REQ_VENDOR_FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b1},
		'{RT_STD_OUT, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_STALL, 7'h00, 1'b1},
		'{RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS, 16'h002A, 16'h0000, 16'h0000,
			1'b1, ucrr_pkg::KIND_ACK, 7'h2A, 1'b1},
		'{RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, {ucrr_pkg::DESC_CONFIG, 8'h00},
			16'h0000, 16'hFFFF, 1'b0, ucrr_pkg::KIND_DATA, 7'h00, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ucrr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ucrr_pkg::CFG_DATA_W-1:0] cfg_data;

	ucrr_req_if req_ch ();
	ucrr_rsp_if rsp_ch ();

	usb_control_request_responder #(
		.EP0_PACKET_BYTES(EP0_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Mirror of the block's registers and address state
	logic [15:0] vendor_code;
	logic [15:0] product_code;
	logic [7:0]  max_power;
	logic [7:0]  poll_interval;
	logic [6:0]  address_reg;
	logic        address_on;

	reply_t answer [$];
	reply_t awaited_replies [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_off_requests = 0;
	int hold_off_served = 0;
	int requests_sent = 0;
	int replies_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] descriptor_byte(logic [7:0] dtype, int i);
		int j;
		if (dtype == ucrr_pkg::DESC_REPORT)
			return REPORT_ROM[i];
		if (dtype == ucrr_pkg::DESC_DEVICE) begin
			case (i)
				7: return 8'(EP0_BYTES);
				8: return vendor_code[7:0];
				9: return vendor_code[15:8];
				10: return product_code[7:0];
				11: return product_code[15:8];
				default: return DEVICE_TMPL[i];
			endcase
		end
		// HID descriptor sits inside the configuration block
		j = (dtype == ucrr_pkg::DESC_HID) ? i + int'(ucrr_pkg::OFS_HID) : i;
		if (j == 8)
			return max_power;
		if (j == 33)
			return poll_interval;
		return CONFIG_TMPL[j];
	endfunction

	function automatic void add_reply(ucrr_pkg::kind_t k, logic [7:0] b, logic pend,
		logic fin);
		answer.push_back('{k, b, pend, fin, address_reg, address_on});
	endfunction

	// Work out the results of one setup packet and update the address state
	function automatic void answer_setup(setup_t s);
		logic dir;
		logic [1:0] rkind;
		logic plain;
		int size;
		int n;
		dir = s.rtype[7];
		rkind = s.rtype[6:5];
		plain = !dir && rkind == 2'd0 && s.rtype[4:0] == 5'd0 && s.index == 16'd0 &&
			s.length == 16'd0;
		answer.delete();
		if (s.code == ucrr_pkg::REQ_GET_DESCRIPTOR && dir && rkind == 2'd0) begin
			size = 0;
			if (s.value[7:0] == 8'd0 && s.index == 16'd0) begin
				case (s.value[15:8])
					ucrr_pkg::DESC_DEVICE: size = int'(ucrr_pkg::LEN_DEVICE);
					ucrr_pkg::DESC_CONFIG: size = int'(ucrr_pkg::LEN_CONFIG);
					ucrr_pkg::DESC_HID: size = int'(ucrr_pkg::LEN_HID);
					ucrr_pkg::DESC_REPORT: size = int'(ucrr_pkg::LEN_REPORT);
					default: size = 0;
				endcase
			end
			n = (int'(s.length) < size) ? int'(s.length) : size;
			if (size == 0)
				add_reply(ucrr_pkg::KIND_STALL, 8'h00, 1'b0, 1'b1);
			else if (n == 0)
				add_reply(ucrr_pkg::KIND_ZLP, 8'h00, 1'b1, 1'b1);
			else begin
				for (int i = 0; i < n; i++)
					add_reply(ucrr_pkg::KIND_DATA, descriptor_byte(s.value[15:8], i),
						((i + 1) % EP0_BYTES == 0) || (i + 1 == n), i + 1 == n);
			end
		end else if (s.code == ucrr_pkg::REQ_SET_ADDRESS && plain) begin
			address_reg = s.value[6:0];
			address_on = 1'b1;
			add_reply(ucrr_pkg::KIND_ACK, 8'h00, 1'b0, 1'b1);
		end else if (s.code == ucrr_pkg::REQ_SET_CONFIG && plain)
			add_reply(ucrr_pkg::KIND_ACK, 8'h00, 1'b0, 1'b1);
		else
			add_reply(ucrr_pkg::KIND_STALL, 8'h00, 1'b0, 1'b1);
	endfunction

	// Mostly well-formed requests, some with one bit flipped, some pure noise
	function automatic setup_t random_setup();
		setup_t s;
		int roll;
		logic [7:0] dtype;
		s = '0;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			case ($urandom_range(0, 3))
				0: dtype = ucrr_pkg::DESC_DEVICE;
				1: dtype = ucrr_pkg::DESC_CONFIG;
				2: dtype = ucrr_pkg::DESC_HID;
				default: dtype = ucrr_pkg::DESC_REPORT;
			endcase
			s.rtype = RT_STD_IN;
			if ($urandom_range(0, 3) == 0)
				s.rtype = RT_STD_IN | 8'($urandom_range(0, 31));
			s.code = ucrr_pkg::REQ_GET_DESCRIPTOR;
			s.value = {dtype, 8'h00};
			case ($urandom_range(0, 4))
				0: s.length = 16'($urandom_range(0, 8));
				1: s.length = 16'($urandom_range(1, 50));
				2: s.length = 16'hFFFF;
				3: s.length = 16'($urandom);
				default: s.length = 16'($urandom_range(8, 46));
			endcase
		end else if (roll < 78) begin
			s.code = ucrr_pkg::REQ_SET_ADDRESS;
			s.value = 16'($urandom);
		end else begin
			s.code = ucrr_pkg::REQ_SET_CONFIG;
			s.value = 16'($urandom);
		end
		roll = $urandom_range(0, 99);
		if (roll < 12)
			s = s ^ (64'd1 << $urandom_range(0, 63));
		else if (roll < 22)
			s = {$urandom, $urandom};
		return s;
	endfunction

	// Offer one request and queue its results once the transaction completes
	task automatic offer(setup_t s, bit typed, reply_t fixed);
		while ($urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.request_type <= s.rtype;
		req_ch.request_code <= s.code;
		req_ch.request_value <= s.value;
		req_ch.request_index <= s.index;
		req_ch.request_length <= s.length;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		answer_setup(s);
		if (typed)
			awaited_replies.push_back(fixed);
		else
			foreach (answer[k])
				awaited_replies.push_back(answer[k]);
		requests_sent++;
	endtask

	// Drop valid and hold until every queued result has arrived
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// Caller lowers cfg_we after the last write
	task automatic write_reg(logic [ucrr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			ucrr_pkg::CFG_VENDOR_CODE: vendor_code = value;
			ucrr_pkg::CFG_PRODUCT_CODE: product_code = value;
			ucrr_pkg::CFG_MAX_POWER: max_power = value[7:0];
			ucrr_pkg::CFG_POLL_INTERVAL: poll_interval = value[7:0];
			default: ;
		endcase
	endtask

	// Result side: check each transaction, then drive ready for the next cycle
	initial begin : reply_side
		int hold_left;
		reply_t got;
		reply_t want;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.kind = rsp_ch.kind;
				got.data_byte = rsp_ch.data_byte;
				got.packet_end = rsp_ch.packet_end;
				got.last = rsp_ch.last;
				got.device_address = rsp_ch.device_address;
				got.address_enabled = rsp_ch.address_enabled;
				if (awaited_replies.size() == 0) begin
					$error("unexpected result: kind %0d, data_byte %0h", got.kind,
						got.data_byte);
					mismatches++;
				end else begin
					want = awaited_replies.pop_front();
					replies_checked++;
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						mismatches++;
					end
					if (got.data_byte !== want.data_byte) begin
						$error("data_byte: expected %0h, got %0h", want.data_byte,
							got.data_byte);
						mismatches++;
					end
					if (got.packet_end !== want.packet_end) begin
						$error("packet_end: expected %0b, got %0b", want.packet_end,
							got.packet_end);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, got.last);
						mismatches++;
					end
					if (got.device_address !== want.device_address) begin
						$error("device_address: expected %0h, got %0h",
							want.device_address, got.device_address);
						mismatches++;
					end
					if (got.address_enabled !== want.address_enabled) begin
						$error("address_enabled: expected %0b, got %0b",
							want.address_enabled, got.address_enabled);
						mismatches++;
					end
				end
			end
			if (hold_off_served != hold_off_requests) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_served = hold_off_requests;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Request side: reset, directed table, then random phases
	initial begin : request_side
		setup_t s;
		reply_t fixed;
		logic [15:0] vid;
		logic [15:0] pid;
		logic [7:0] mp;
		logic [7:0] pi;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ucrr_pkg::CFG_VENDOR_CODE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.request_type = '0;
		req_ch.request_code = '0;
		req_ch.request_value = '0;
		req_ch.request_index = '0;
		req_ch.request_length = '0;
		vendor_code = ucrr_pkg::RST_VENDOR_CODE;
		product_code = ucrr_pkg::RST_PRODUCT_CODE;
		max_power = ucrr_pkg::RST_MAX_POWER;
		poll_interval = ucrr_pkg::RST_POLL_INTERVAL;
		address_reg = 7'd0;
		address_on = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with the reset register values
		foreach (probe_table[i]) begin
			s = '{probe_table[i].rtype, probe_table[i].code, probe_table[i].value,
				probe_table[i].index, probe_table[i].length};
			fixed = '{probe_table[i].kind, 8'h00,
				probe_table[i].kind == ucrr_pkg::KIND_ZLP, 1'b1,
				probe_table[i].addr, probe_table[i].on};
			offer(s, probe_table[i].typed, fixed);
		end
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					vid = 16'hFFFF;
					pid = 16'h0000;
					mp = 8'd250;
					pi = 8'd255;
				end
				1: begin
					vid = 16'h0000;
					pid = 16'hFFFF;
					mp = 8'd0;
					pi = 8'd1;
				end
				default: begin
					vid = 16'($urandom);
					pid = 16'($urandom);
					mp = 8'($urandom_range(0, 250));
					pi = 8'($urandom_range(1, 255));
				end
			endcase
			write_reg(ucrr_pkg::CFG_VENDOR_CODE, vid);
			write_reg(ucrr_pkg::CFG_PRODUCT_CODE, pid);
			write_reg(ucrr_pkg::CFG_MAX_POWER, {8'h00, mp});
			write_reg(ucrr_pkg::CFG_POLL_INTERVAL, {8'h00, pi});
			cfg_we <= 1'b0;

			// Cycle through no idling, sender gaps, receiver stalls, both
			case (phase % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 53;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 53;
				end
				default: begin
					gap_pct = 25;
					stall_pct = 25;
				end
			endcase
			// Back up the result side while requests keep coming
			if (phase == 0)
				hold_off_requests++;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				offer(random_setup(), 1'b0, '0);
				// Let the block empty out now and then
				if (phase == 1 && n % 8 == 7)
					drain();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d setup requests over %0d register settings, %0d results checked.",
			requests_sent, RANDOM_PHASES + 1, replies_checked);
		$display("Directed extremes and error cases first, then random requests under idling.");
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: usb_control_request_responder.f
+incdir+rtl
rtl/ucrr_pkg.sv
rtl/ucrr_ifs.sv
rtl/ucrr_ctrl.sv
rtl/ucrr_datapath.sv
rtl/usb_control_request_responder.sv
test/usb_control_request_responder_tb.sv
